### hdl/gwf_pkg.sv
// package: payload structs, controller commands and codes for the water flow grid
`default_nettype none
package gwf_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        cell_index;
    logic signed [15:0] terrain_height;
  } gwf_in_t;

  typedef struct packed {
    logic signed [15:0] water_level;
    logic               op_done;
  } gwf_out_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;
  localparam logic [1:0] OP_FLOW  = 2'd3;

  localparam logic [1:0] WS_ZERO = 2'd0;
  localparam logic [1:0] WS_ADD  = 2'd1;
  localparam logic [1:0] WS_CUR  = 2'd2;

  localparam logic REG_FLOW_STEP = 1'b0;
  localparam logic REG_GRID_SIDE = 1'b1;

  localparam logic [1:0] NB_RIGHT = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;

  typedef struct packed {
    logic       lvl_re;
    logic       lvl_we;
    logic [1:0] lvl_wsel;
    logic       ter_re;
    logic       ter_we;
    logic       cur_load;
    logic       cur_dec;
    logic       out_cap;
    logic       out_lvl;
  } gwf_cmd_t;

  typedef struct packed {
    logic move;
  } gwf_sts_t;

endpackage
`default_nettype wire

### hdl/grid_water_flow_step.sv
// top level: configuration registers, controller and datapath of the water flow grid
//
// Usage: an operation is accepted on a clock edge with start high and busy low;
// in_data carries op, cell_index and terrain_height. Every accepted transaction
// yields exactly one result: out_valid is high for one cycle with out_data
// (water_level on a read, zero otherwise, and op_done). The receiver cannot stall.
// Raise and flow each sweep the whole grid cell by cell; both are bound by the
// single port of the level memory, which carries every level read and write of the sweep.
// One transaction at a time; a new one may start in the cycle its result shows.
// Reset: synchronous active low rst_n; afterwards a clearing pass zeroes the level
// memory while busy stays high. Terrain memory is not cleared. flow_step and
// grid_side sit on the APB port at byte addresses 0 and 4; the user must write
// them only while the block is idle, as the block itself does not enforce it.
`default_nettype none
module grid_water_flow_step import gwf_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int LEVEL_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire gwf_in_t     in_data,
  output logic             out_valid,
  output gwf_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  logic [14:0]   flow_step_r;
  logic [6:0]    grid_side_r;
  logic          wr_en;
  gwf_cmd_t      cmd;
  gwf_sts_t      sts;
  logic [AW-1:0] addr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_step_r <= 15'd16;
      grid_side_r <= 7'd64;
    end else if (wr_en) begin
      if (paddr[2] == REG_FLOW_STEP) begin
        flow_step_r <= pwdata[14:0];
      end else begin
        grid_side_r <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GRID_SIDE) ? {25'd0, grid_side_r} : {17'd0, flow_step_r};

  gwf_ctrl #(
    .MAX_SIDE(MAX_SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .grid_side (grid_side_r),
    .sts       (sts),
    .cmd       (cmd),
    .addr      (addr),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gwf_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .addr       (addr),
    .terrain_in (in_data.terrain_height),
    .flow_step  (flow_step_r),
    .sts        (sts),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

### hdl/gwf_datapath.sv
// datapath: level and terrain memories, current cell register, transfer test
`default_nettype none
module gwf_datapath import gwf_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int LEVEL_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire gwf_cmd_t                               cmd,
  input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   addr,
  input  wire logic signed [15:0]                     terrain_in,
  input  wire logic [14:0]                            flow_step,
  output gwf_sts_t                                    sts,
  output gwf_out_t                                    out_data
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int LB    = LEVEL_BITS;
  localparam int CW    = ((LB > 16) ? LB : 16) + 2;

  logic signed [LB-1:0] lvl_mem [CELLS];
  logic signed [15:0]   ter_mem [CELLS];

  logic signed [LB-1:0] lvl_rd_r;
  logic signed [15:0]   ter_rd_r;
  logic signed [LB-1:0] cur_r;
  logic signed [15:0]   out_lvl_r;

  logic signed [CW-1:0] step_w;
  logic signed [CW-1:0] nb_w;
  logic signed [CW-1:0] cur_w;
  logic signed [CW-1:0] ter_w;
  logic signed [CW-1:0] nb_plus;
  logic signed [CW-1:0] cur_minus;
  logic signed [LB-1:0] nb_sat;
  logic signed [LB-1:0] cur_sat;
  logic signed [LB-1:0] wdata;
  logic signed [31:0]   rd_ext;

  function automatic logic signed [LB-1:0] sat_lvl(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    hi = CW'((64'sd1 <<< (LB - 1)) - 64'sd1);
    lo = -hi - CW'(1);
    if (v > hi) begin
      sat_lvl = LB'(hi);
    end else if (v < lo) begin
      sat_lvl = LB'(lo);
    end else begin
      sat_lvl = LB'(v);
    end
  endfunction

  assign step_w    = CW'($signed({1'b0, flow_step}));
  assign nb_w      = CW'(lvl_rd_r);
  assign cur_w     = CW'(cur_r);
  assign ter_w     = CW'(ter_rd_r);
  assign nb_plus   = nb_w + step_w;
  assign cur_minus = cur_w - step_w;
  assign nb_sat    = sat_lvl(nb_plus);
  assign cur_sat   = sat_lvl(cur_minus);
  assign sts.move  = (nb_w < cur_minus) && (cur_w > ter_w);
  assign rd_ext    = 32'(lvl_rd_r);

  always_comb begin
    unique case (cmd.lvl_wsel)
      WS_ADD:  wdata = nb_sat;
      WS_CUR:  wdata = cur_r;
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl_we) begin
      lvl_mem[addr] <= wdata;
    end
    if (cmd.lvl_re) begin
      lvl_rd_r <= lvl_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ter_we) begin
      ter_mem[addr] <= terrain_in;
    end
    if (cmd.ter_re) begin
      ter_rd_r <= ter_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur_r <= lvl_rd_r;
    end else if (cmd.cur_dec) begin
      cur_r <= cur_sat;
    end
    if (cmd.out_cap) begin
      out_lvl_r <= cmd.out_lvl ? rd_ext[15:0] : 16'sd0;
    end
  end

  assign out_data.water_level = out_lvl_r;
  assign out_data.op_done     = 1'b1;

endmodule
`default_nettype wire

### hdl/gwf_ctrl.sv
// controller: clearing pass, operation sequencing, raise and flow sweeps
`default_nettype none
module gwf_ctrl import gwf_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire gwf_in_t                                in_data,
  input  wire logic [6:0]                             grid_side,
  input  wire gwf_sts_t                               sts,
  output gwf_cmd_t                                    cmd,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]        addr,
  output logic                                        busy,
  output logic                                        out_valid
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RD_WAIT = 4'd2;
  localparam logic [3:0] S_R_RD    = 4'd3;
  localparam logic [3:0] S_R_WR    = 4'd4;
  localparam logic [3:0] S_F_RC    = 4'd5;
  localparam logic [3:0] S_F_LC    = 4'd6;
  localparam logic [3:0] S_F_NRD   = 4'd7;
  localparam logic [3:0] S_F_NCHK  = 4'd8;
  localparam logic [3:0] S_F_WC    = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [XW-1:0] y_r, y_nxt;
  logic [SW-1:0] n_r, n_nxt;
  logic [1:0]    nb_r, nb_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [SW-1:0] side_c;
  logic [SW-1:0] x_s, y_s, n_m1, n_m2;
  logic          idx_ok;
  logic          border;
  logic          x_last, y_last;
  logic          nb_ok;
  logic [AW-1:0] naddr;
  logic [AW-1:0] n_a;
  logic          adv;
  logic          fin;
  logic [3:0]    loop_state;

  always_comb begin
    if (grid_side < 7'd3) begin
      side_c = SW'(3);
    end else if (int'(grid_side) > MAX_SIDE) begin
      side_c = SW'(MAX_SIDE);
    end else begin
      side_c = SW'(grid_side);
    end
  end

  assign x_s    = SW'(x_r);
  assign y_s    = SW'(y_r);
  assign n_m1   = n_r - SW'(1);
  assign n_m2   = n_r - SW'(2);
  assign x_last = (x_s == n_m1);
  assign y_last = (y_s == n_m1);
  assign border = (x_r == '0) || (y_r == '0) || (x_s == n_m2) || (y_s == n_m2);
  assign idx_ok = int'(in_data.cell_index) < CELLS;
  assign n_a    = AW'(n_r);

  always_comb begin
    unique case (nb_r)
      NB_RIGHT: begin
        nb_ok = !x_last;
        naddr = addr_r + AW'(1);
      end
      NB_LEFT: begin
        nb_ok = (x_r != '0);
        naddr = addr_r - AW'(1);
      end
      NB_DOWN: begin
        nb_ok = !y_last;
        naddr = addr_r + n_a;
      end
      default: begin
        nb_ok = (y_r != '0);
        naddr = addr_r - n_a;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    addr          = addr_r;
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    n_nxt         = n_r;
    nb_nxt        = nb_r;
    out_valid_nxt = 1'b0;
    adv           = 1'b0;
    fin           = 1'b0;
    loop_state    = S_R_RD;
    unique case (state_r)
      S_CLEAR: begin
        cmd.lvl_we   = 1'b1;
        cmd.lvl_wsel = WS_ZERO;
        addr_nxt     = addr_r + AW'(1);
        if (addr_r == LAST) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          n_nxt    = side_c;
          x_nxt    = '0;
          y_nxt    = '0;
          addr_nxt = '0;
          unique case (in_data.op)
            OP_LOAD: begin
              addr       = AW'(in_data.cell_index);
              cmd.ter_we = idx_ok;
              fin        = 1'b1;
            end
            OP_READ: begin
              addr = AW'(in_data.cell_index);
              if (idx_ok) begin
                cmd.lvl_re = 1'b1;
                state_nxt  = S_RD_WAIT;
              end else begin
                fin = 1'b1;
              end
            end
            OP_RAISE: state_nxt = S_R_RD;
            default:  state_nxt = S_F_RC;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.out_lvl = 1'b1;
        fin         = 1'b1;
      end
      S_R_RD: begin
        if (border) begin
          cmd.lvl_re = 1'b1;
          state_nxt  = S_R_WR;
        end else begin
          adv = 1'b1;
        end
      end
      S_R_WR: begin
        cmd.lvl_we   = 1'b1;
        cmd.lvl_wsel = WS_ADD;
        adv          = 1'b1;
      end
      S_F_RC: begin
        cmd.lvl_re = 1'b1;
        state_nxt  = S_F_LC;
      end
      S_F_LC: begin
        cmd.cur_load = 1'b1;
        nb_nxt       = NB_RIGHT;
        state_nxt    = S_F_NRD;
      end
      S_F_NRD: begin
        if (nb_ok) begin
          addr       = naddr;
          cmd.lvl_re = 1'b1;
          cmd.ter_re = 1'b1;
          state_nxt  = S_F_NCHK;
        end else if (nb_r == NB_UP) begin
          state_nxt = S_F_WC;
        end else begin
          nb_nxt = nb_r + 2'd1;
        end
      end
      S_F_NCHK: begin
        addr         = naddr;
        cmd.lvl_we   = sts.move;
        cmd.lvl_wsel = WS_ADD;
        cmd.cur_dec  = sts.move;
        if (nb_r == NB_UP) begin
          state_nxt = S_F_WC;
        end else begin
          nb_nxt    = nb_r + 2'd1;
          state_nxt = S_F_NRD;
        end
      end
      S_F_WC: begin
        cmd.lvl_we   = 1'b1;
        cmd.lvl_wsel = WS_CUR;
        loop_state   = S_F_RC;
        adv          = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (adv) begin
      if (x_last && y_last) begin
        fin = 1'b1;
      end else begin
        state_nxt = loop_state;
        addr_nxt  = addr_r + AW'(1);
        if (x_last) begin
          x_nxt = '0;
          y_nxt = y_r + XW'(1);
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
    end

    if (fin) begin
      cmd.out_cap   = 1'b1;
      out_valid_nxt = 1'b1;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      x_r         <= '0;
      y_r         <= '0;
      n_r         <= SW'(3);
      nb_r        <= NB_RIGHT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      n_r         <= n_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.lvl_we && cmd.lvl_re))
    else $error("level memory read and write in the same cycle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("accepted transaction neither in progress nor done");

  a_sweep_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F_NCHK || state_r == S_R_WR) |-> (x_s < n_r && y_s < n_r))
    else $error("sweep position outside the grid");

endmodule
`default_nettype wire
